// ----- design/assert_macros.svh -----
// Assertion macros shared by the letter naming RTL.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");
`define BB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define BB_ASSERT(lbl, clk, rst_n, prop)
`define BB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/bb26_pkg.sv -----
// Shared types, constants and constant functions for the base-26 letter block.
// No dependencies; imported by bb26_emit and bijective_base26_letters.
`timescale 1ns / 1ps
package bb26_pkg;

    localparam int VALUE_BITS_DEF  = 50;
    localparam int MAX_LETTERS_DEF = 11;
    localparam int MAX_LETTERS_LIM = 14;

    // Wide enough for 26^14 plus the running sums, exact with no saturation
    localparam int WIDE_W  = 70;
    localparam int POS_W   = $clog2(MAX_LETTERS_LIM);
    localparam int DIGIT_W = 5;

    localparam int RADIX = 26;
    localparam logic [6:0] LETTER_A = 7'd97;
    localparam logic [6:0] LETTER_Z = 7'd122;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(RADIX - 1);

    typedef logic [WIDE_W-1:0] wide_t;

    typedef struct packed {
        logic             valid;
        logic             sat;
        logic [POS_W-1:0] pos;
    } em_load_t;

    function automatic wide_t pow26(input int k);
        wide_t p;
        p = wide_t'(1);
        for (int j = 0; j < k; j++)
        begin
            p = p * wide_t'(RADIX);
        end
        return p;
    endfunction

    function automatic wide_t mult26(input int k, input int d);
        return pow26(k) * wide_t'(d);
    endfunction

    // 26 + 26^2 + ... + 26^i
    function automatic wide_t cumul26(input int i);
        wide_t s;
        s = '0;
        for (int j = 1; j <= i; j++)
        begin
            s = s + pow26(j);
        end
        return s;
    endfunction

endpackage

// ----- design/bb26_emit.sv -----
// Letter emitter: holds one name and sends one letter per cycle, most significant first.
// Depends on bb26_pkg.
`timescale 1ns / 1ps
module bb26_emit
    import bb26_pkg::*;
#(
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    parameter int MAX_LETTERS = MAX_LETTERS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  em_load_t              load,
    input  logic [VALUE_BITS-1:0] rem,
    output logic                  free,
    output logic                  strobe,
    output logic [6:0]            letter,
    output logic                  is_last
);

    logic                  valid_reg, valid_next;
    logic                  sat_reg, sat_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic                  strobe_reg, strobe_next;
    logic                  last_reg, last_next;
    logic [6:0]            letter_reg, letter_next;

    wide_t               ext;
    wide_t               sub;
    logic [DIGIT_W-1:0]  digit;

    assign free = !valid_reg || (pos_reg == '0);

    always_comb
    begin
        ext   = wide_t'(rem_reg);
        digit = '0;
        sub   = '0;
        // digit is the largest count of 26^pos that fits in the remainder
        for (int k = 0; k < MAX_LETTERS; k++)
        begin
            if (pos_reg == POS_W'(k))
            begin
                for (int d = 1; d < RADIX; d++)
                begin
                    if (ext >= mult26(k, d))
                    begin
                        digit = DIGIT_W'(d);
                        sub   = mult26(k, d);
                    end
                end
            end
        end
        if (sat_reg)
        begin
            digit = DIGIT_MAX;
        end

        strobe_next = valid_reg;
        last_next   = valid_reg && (pos_reg == '0);
        letter_next = LETTER_A + {2'b00, digit};

        valid_next = valid_reg;
        sat_next   = sat_reg;
        pos_next   = pos_reg;
        rem_next   = VALUE_BITS'(ext - sub);
        if (load.valid && free)
        begin
            valid_next = 1'b1;
            sat_next   = load.sat;
            pos_next   = load.pos;
            rem_next   = rem;
        end
        else if (valid_reg)
        begin
            if (pos_reg == '0)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg - POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sat_reg    <= sat_next;
        pos_reg    <= pos_next;
        rem_reg    <= rem_next;
        letter_reg <= letter_next;
    end

    assign strobe  = strobe_reg;
    assign letter  = letter_reg;
    assign is_last = last_reg;

endmodule

// ----- design/bijective_base26_letters.sv -----
// Bijective base-26 naming: value 1 -> a, 26 -> z, 27 -> aa, zero counts as one.
// A name has 1 to MAX_LETTERS letters; the emitter sends one letter per cycle and
// busy holds off requests while it is occupied. A taken request passes the
// cleaned-value, length and remainder stages, then the emitter registers its first
// letter. Letters come out on consecutive cycles with no gaps and the receiver
// cannot stall them. Names longer than MAX_LETTERS become MAX_LETTERS letters z.
// Depends on bb26_pkg, bb26_emit and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bijective_base26_letters
    import bb26_pkg::*;
#(
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    parameter int MAX_LETTERS = MAX_LETTERS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  strobe,
    output logic [6:0]            letter,
    output logic                  is_last
);

    // stage 1: cleaned value
    logic                  s1_valid_reg, s1_valid_next;
    logic [VALUE_BITS-1:0] s1_n_reg, s1_n_next;
    // stage 2: length found
    logic                  s2_valid_reg, s2_valid_next;
    logic [VALUE_BITS-1:0] s2_n_reg, s2_n_next;
    logic [POS_W-1:0]      s2_pos_reg, s2_pos_next;
    logic                  s2_sat_reg, s2_sat_next;
    // stage 3: remainder ready for digit extraction
    logic                  s3_valid_reg, s3_valid_next;
    logic [VALUE_BITS-1:0] s3_rem_reg, s3_rem_next;
    logic [POS_W-1:0]      s3_pos_reg, s3_pos_next;
    logic                  s3_sat_reg, s3_sat_next;

    logic     em_free;
    em_load_t em_load;
    logic     s1_take, s2_take, s3_take;
    logic     accept;
    logic [MAX_LETTERS-1:0] fits;
    wide_t    offset;

    assign s3_take = !s3_valid_reg || em_free;
    assign s2_take = !s2_valid_reg || s3_take;
    assign s1_take = !s1_valid_reg || s2_take;
    assign busy    = !s1_take;
    assign accept  = start && s1_take;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_n_next     = s1_n_reg;
        if (s1_take)
        begin
            s1_valid_next = accept;
            s1_n_next     = (value == '0) ? VALUE_BITS'(1) : value;
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_LETTERS; i++)
        begin
            fits[i] = wide_t'(s1_n_reg) <= cumul26(i + 1);
        end
        s2_valid_next = s2_valid_reg;
        s2_n_next     = s2_n_reg;
        s2_pos_next   = s2_pos_reg;
        s2_sat_next   = s2_sat_reg;
        if (s2_take)
        begin
            s2_valid_next = s1_valid_reg;
            s2_n_next     = s1_n_reg;
            s2_sat_next   = !(|fits);
            s2_pos_next   = POS_W'(MAX_LETTERS - 1);
            // pick the shortest length that holds the value
            for (int i = MAX_LETTERS - 1; i >= 0; i--)
            begin
                if (fits[i])
                begin
                    s2_pos_next = POS_W'(i);
                end
            end
        end
    end

    always_comb
    begin
        offset = '0;
        for (int k = 0; k < MAX_LETTERS; k++)
        begin
            if (s2_pos_reg == POS_W'(k))
            begin
                offset = cumul26(k);
            end
        end
        s3_valid_next = s3_valid_reg;
        s3_rem_next   = s3_rem_reg;
        s3_pos_next   = s3_pos_reg;
        s3_sat_next   = s3_sat_reg;
        if (s3_take)
        begin
            s3_valid_next = s2_valid_reg;
            s3_rem_next   = VALUE_BITS'(wide_t'(s2_n_reg) - wide_t'(1) - offset);
            s3_pos_next   = s2_pos_reg;
            s3_sat_next   = s2_sat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_n_reg   <= s1_n_next;
        s2_n_reg   <= s2_n_next;
        s2_pos_reg <= s2_pos_next;
        s2_sat_reg <= s2_sat_next;
        s3_rem_reg <= s3_rem_next;
        s3_pos_reg <= s3_pos_next;
        s3_sat_reg <= s3_sat_next;
    end

    assign em_load.valid = s3_valid_reg;
    assign em_load.sat   = s3_sat_reg;
    assign em_load.pos   = s3_pos_reg;

    bb26_emit #(
        .VALUE_BITS  (VALUE_BITS),
        .MAX_LETTERS (MAX_LETTERS)
    ) u_emit (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (em_load),
        .rem     (s3_rem_reg),
        .free    (em_free),
        .strobe  (strobe),
        .letter  (letter),
        .is_last (is_last)
    );

    `BB_ASSERT(a_letter_range, clk, rst_n, !strobe || (letter >= LETTER_A && letter <= LETTER_Z))
    `BB_ASSERT(a_last_marked, clk, rst_n, !is_last || strobe)
    `BB_ASSERT_NEXT(a_name_unbroken, clk, rst_n, strobe && !is_last, strobe)
    `BB_ASSERT_NEXT(a_request_held, clk, rst_n, start && !busy, s1_valid_reg)

endmodule
